// ----- src/cha_pkg.sv -----
// Shared types and constants for the contiguous hole allocator.
package cha_pkg;

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;
  localparam logic FIT_FIRST    = 1'b0;
  localparam logic FIT_BEST     = 1'b1;

  typedef struct packed {
    logic       busy;
    logic [7:0] owner;
  } cell_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_APPLY = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

endpackage

// ----- src/cha_if.sv -----
// Channel interfaces: request, response and configuration write.
interface cha_req_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] owner_id;
  logic [7:0] req_size;
  modport source (output valid, func, owner_id, req_size, input ready);
  modport sink (input valid, func, owner_id, req_size, output ready);
endinterface

interface cha_rsp_if;
  logic       valid;
  logic       ready;
  logic       ok;
  logic [6:0] start_unit;
  logic [6:0] hole_count;
  logic [7:0] used_units;
  modport source (output valid, ok, start_unit, hole_count, used_units, input ready);
  modport sink (input valid, ok, start_unit, hole_count, used_units, output ready);
endinterface

interface cha_cfg_if;
  logic valid;
  logic ready;
  logic fit_mode;
  modport source (output valid, fit_mode, input ready);
  modport sink (input valid, fit_mode, output ready);
endinterface

// ----- src/contiguous_hole_allocator.sv -----
// Top level: contiguous run allocator over a rotating ring of unit cells.
//
//  channel  dir  payload                                      beat
//  cfg      in   fit_mode                                     valid & ready
//  req      in   func, owner_id, req_size                     valid & ready
//  rsp      out  ok, start_unit, hole_count, used_units       valid & ready
//
// An item after its beat makes one scan pass over the ring (a step per unit,
// then a last step that closes the final run) and one update pass that
// rewrites each unit as it passes the head and counts holes and use.
// The ring of cells moves one unit through the head per cycle in both passes.
// Reset clears all busy flags at once; cfg is always ready.
// A result waits in the output register; the next req beat is taken meanwhile.
module contiguous_hole_allocator #(
  parameter int MEM_UNITS = 128
) (
  input  logic clk,
  input  logic rst,
  cha_cfg_if.sink   cfg,
  cha_req_if.sink   req,
  cha_rsp_if.source rsp
);

  localparam int PW = $clog2(MEM_UNITS + 1);
  localparam int CW = (PW > 8) ? PW : 8;
  localparam logic [CW-1:0] NU = CW'(MEM_UNITS);

  cha_pkg::state_t state;
  cha_pkg::cell_t  ring [MEM_UNITS];
  cha_pkg::cell_t  head_new;
  cha_pkg::cell_t  head;

  logic          fit_mode;
  logic          func;
  logic [7:0]    owner_id;
  logic [CW-1:0] req_size;
  logic [CW-1:0] pos;
  logic [CW-1:0] run;
  logic [CW-1:0] best;
  logic [CW-1:0] chosen;
  logic          found;
  logic          rel_act;
  logic          prev_busy;
  logic [CW-1:0] used;
  logic [CW-1:0] holes;
  logic          shift;
  logic          is_free;
  logic          rel_match;
  logic          alloc_hit;
  logic          rel_on;
  logic          fits;

  assign head = ring[0];
  assign shift = ((state == cha_pkg::S_SCAN) && (pos != NU)) || (state == cha_pkg::S_APPLY);

  for (genvar i = 0; i < MEM_UNITS; i++) begin : g_ring
    cha_pkg::cell_t d;
    if (i == MEM_UNITS - 1) begin : g_tail
      assign d = head_new;
    end else begin : g_mid
      assign d = ring[i+1];
    end
    cha_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .d(d), .q(ring[i]));
  end

  assign is_free   = (pos != NU) && !head.busy;
  assign rel_match = head.busy && (head.owner == owner_id);
  assign fits      = (run != '0) && (run >= req_size);
  assign alloc_hit = found && (func == cha_pkg::FUNC_ALLOC) && (pos >= chosen)
                     && ({1'b0, pos} < ({1'b0, chosen} + {1'b0, req_size}));
  assign rel_on    = found && (func == cha_pkg::FUNC_RELEASE) && rel_match
                     && ((pos == chosen) || rel_act);

  always_comb begin
    head_new = head;
    if (state == cha_pkg::S_APPLY) begin
      if (alloc_hit) begin
        head_new.busy  = 1'b1;
        head_new.owner = owner_id;
      end else if (rel_on) begin
        head_new.busy = 1'b0;
      end
    end
  end

  assign req.ready = (state == cha_pkg::S_IDLE);
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode <= cha_pkg::FIT_BEST;
    end else if (cfg.valid) begin
      fit_mode <= cfg.fit_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cha_pkg::S_IDLE;
      rsp.valid <= 1'b0;
      found     <= 1'b0;
      rel_act   <= 1'b0;
    end else begin
      // in S_DONE the output register is reloaded below instead
      if (rsp.valid && rsp.ready && (state != cha_pkg::S_DONE)) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        cha_pkg::S_IDLE: begin
          if (req.valid) begin
            func     <= req.func;
            owner_id <= req.owner_id;
            req_size <= CW'(req.req_size);
            pos      <= '0;
            run      <= '0;
            best     <= NU;
            chosen   <= '0;
            found    <= 1'b0;
            state    <= cha_pkg::S_SCAN;
          end
        end
        cha_pkg::S_SCAN: begin
          if (func == cha_pkg::FUNC_RELEASE) begin
            if (!found && (pos != NU) && rel_match) begin
              found  <= 1'b1;
              chosen <= pos;
            end
          end else if ((req_size != '0) && (req_size <= NU)) begin
            if (is_free) begin
              run <= run + 1'b1;
            end else begin
              run <= '0;
              if (fits) begin
                if (fit_mode == cha_pkg::FIT_FIRST) begin
                  if (!found) begin
                    found  <= 1'b1;
                    chosen <= pos - run;
                  end
                end else if (run <= best) begin
                  found  <= 1'b1;
                  best   <= run;
                  chosen <= pos - run;
                end
              end
            end
          end
          if (pos == NU) begin
            pos       <= '0;
            used      <= '0;
            holes     <= '0;
            prev_busy <= 1'b1;
            rel_act   <= 1'b0;
            state     <= cha_pkg::S_APPLY;
          end else begin
            pos <= pos + 1'b1;
          end
        end
        cha_pkg::S_APPLY: begin
          rel_act   <= rel_on;
          prev_busy <= head_new.busy;
          used      <= used + CW'(head_new.busy);
          holes     <= holes + CW'(!head_new.busy && prev_busy);
          pos       <= pos + 1'b1;
          if (pos == NU - 1'b1) begin
            state <= cha_pkg::S_DONE;
          end
        end
        cha_pkg::S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid      <= 1'b1;
            rsp.ok         <= found;
            rsp.start_unit <= found ? chosen[6:0] : 7'd0;
            rsp.hole_count <= holes[6:0];
            rsp.used_units <= used[7:0];
            state          <= cha_pkg::S_IDLE;
          end
        end
        default: begin
          state <= cha_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/cha_cell.sv -----
// One unit of the rotating map: busy flag and owner id.
module cha_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  cha_pkg::cell_t d,
  output cha_pkg::cell_t q
);

  // owner is only meaningful while busy, so it carries no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      q.busy <= 1'b0;
    end else if (shift) begin
      q.busy <= d.busy;
    end
    if (shift) begin
      q.owner <= d.owner;
    end
  end

endmodule
